>>> sv/bdlp_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
package bdlp_pkg;

    // Width of every mask field carried on the streams
    localparam int FIELD_W = 5;
    // Width of the configuration write data and of the register index
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    // Stream data widths, rounded up to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0]   DEBOUNCE_TICKS_RST    = 16'd100;
    localparam logic [CFG_W-1:0]   LONG_PRESS_TICKS_RST  = 16'd1000;
    localparam logic [FIELD_W-1:0] LONG_PRESS_ENABLE_RST = 5'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS    = 2'd0,
        CFG_LONG_PRESS_TICKS  = 2'd1,
        CFG_LONG_PRESS_ENABLE = 2'd2
    } cfg_index_t;

    // What one channel sees of the shared state on a tick
    typedef struct packed {
        logic pin;
        logic prev_pin;
        logic level;
        logic enable;
    } lane_in_t;

    // What one channel reports back on a tick
    typedef struct packed {
        logic flip;
        logic long_press;
    } lane_out_t;

endpackage

>>> sv/bdlp_channel.sv
// One channel: debounce countdown, recheck flag and long-press countdown.
module bdlp_channel
    import bdlp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  lane_in_t               lane_in,
    input  logic [COUNT_WIDTH-1:0] deb_load,
    input  logic [COUNT_WIDTH-1:0] hold_load,
    output lane_out_t              lane_out
);

    logic [COUNT_WIDTH-1:0] deb_cnt_reg, deb_cnt_next;
    logic                   deb_armed_reg, deb_armed_next;
    logic                   recheck_reg, recheck_next;
    logic [COUNT_WIDTH-1:0] hold_cnt_reg, hold_cnt_next;
    logic                   hold_armed_reg, hold_armed_next;

    logic edge_seen;
    logic check;
    logic expire;
    logic cnt_low;
    logic hold_low;

    assign cnt_low  = (deb_cnt_reg <= COUNT_WIDTH'(1));
    assign hold_low = (hold_cnt_reg <= COUNT_WIDTH'(1));
    assign edge_seen = (lane_in.prev_pin == lane_in.level) && (lane_in.pin != lane_in.level);

    always_comb begin
        deb_cnt_next    = deb_cnt_reg;
        deb_armed_next  = deb_armed_reg;
        recheck_next    = recheck_reg;
        hold_cnt_next   = hold_cnt_reg;
        hold_armed_next = hold_armed_reg;
        check           = 1'b0;
        expire          = 1'b0;

        // Long-press countdown runs on the state from the start of the tick
        if (hold_armed_reg) begin
            if (hold_low) begin
                hold_armed_next = 1'b0;
                hold_cnt_next   = '0;
                expire          = 1'b1;
            end else begin
                hold_cnt_next = hold_cnt_reg - COUNT_WIDTH'(1);
            end
        end

        priority if (edge_seen) begin
            deb_cnt_next   = deb_load;
            deb_armed_next = 1'b1;
            recheck_next   = 1'b0;
        end else if (recheck_reg) begin
            recheck_next = 1'b0;
            check        = 1'b1;
        end else if (deb_armed_reg) begin
            if (cnt_low) begin
                deb_armed_next = 1'b0;
                deb_cnt_next   = '0;
                check          = 1'b1;
            end else begin
                deb_cnt_next = deb_cnt_reg - COUNT_WIDTH'(1);
            end
        end else begin
            // Idle: hold the debounce state
        end

        if (check) begin
            priority if (!lane_in.level && lane_in.pin) begin
                if (lane_in.enable) begin
                    hold_cnt_next   = hold_load;
                    hold_armed_next = 1'b1;
                end
            end else if (lane_in.level && !lane_in.pin) begin
                if (lane_in.enable) begin
                    hold_armed_next = 1'b0;
                end
            end else begin
                // Pin bounced back before the check: flip anyway, look again next tick
                recheck_next = 1'b1;
            end
        end
    end

    assign lane_out.flip       = check;
    assign lane_out.long_press = expire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_cnt_reg    <= '0;
            deb_armed_reg  <= 1'b0;
            recheck_reg    <= 1'b0;
            hold_cnt_reg   <= '0;
            hold_armed_reg <= 1'b0;
        end else if (step) begin
            deb_cnt_reg    <= deb_cnt_next;
            deb_armed_reg  <= deb_armed_next;
            recheck_reg    <= recheck_next;
            hold_cnt_reg   <= hold_cnt_next;
            hold_armed_reg <= hold_armed_next;
        end
    end

endmodule

>>> sv/button_debounce_long_press.sv
// Each result is registered on the transfer of its input tick.
// Throughput: one tick per cycle; the input is taken whenever the result register is
// empty or being drained, and every channel updates in parallel in that same cycle.
// Reset (aresetn low, synchronous) restores the configuration defaults, clears all
// counters and levels, and empties the result register; the next tick loads levels.
module button_debounce_long_press
    import bdlp_pkg::*;
#(
    parameter int CHANNELS    = 5,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] pin_levels, [7:5] zero
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [4:0] level_mask, [9:5] change_mask,
                                            // [14:10] long_press_mask, [15] zero
    // Configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0]   debounce_ticks_reg;
    logic [CFG_W-1:0]   long_press_ticks_reg;
    logic [FIELD_W-1:0] long_press_enable_reg;

    logic                started_reg;
    logic [CHANNELS-1:0] level_reg, level_next;
    logic [CHANNELS-1:0] prev_pin_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                   accept;
    logic                   step;
    logic [CHANNELS-1:0]    pins;
    logic [CHANNELS-1:0]    enable;
    logic [CHANNELS-1:0]    change;
    logic [CHANNELS-1:0]    long_press;
    logic [COUNT_WIDTH-1:0] deb_load;
    logic [COUNT_WIDTH-1:0] hold_load;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign step     = accept && started_reg;

    assign pins      = CHANNELS'(s_tdata[FIELD_W-1:0]);
    assign enable    = CHANNELS'(long_press_enable_reg);
    assign deb_load  = COUNT_WIDTH'(debounce_ticks_reg);
    assign hold_load = COUNT_WIDTH'(long_press_ticks_reg);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg    <= DEBOUNCE_TICKS_RST;
            long_press_ticks_reg  <= LONG_PRESS_TICKS_RST;
            long_press_enable_reg <= LONG_PRESS_ENABLE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_TICKS:    debounce_ticks_reg    <= cfg_wdata;
                CFG_LONG_PRESS_TICKS:  long_press_ticks_reg  <= cfg_wdata;
                CFG_LONG_PRESS_ENABLE: long_press_enable_reg <= cfg_wdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        lane_in_t  lane_in;
        lane_out_t lane_out;

        assign lane_in.pin      = pins[i];
        assign lane_in.prev_pin = prev_pin_reg[i];
        assign lane_in.level    = level_reg[i];
        assign lane_in.enable   = enable[i];

        bdlp_channel #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_channel (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .lane_in   (lane_in),
            .deb_load  (deb_load),
            .hold_load (hold_load),
            .lane_out  (lane_out)
        );

        assign change[i]     = lane_out.flip;
        assign long_press[i] = lane_out.long_press;
    end

    always_comb begin
        if (started_reg) begin
            level_next   = level_reg ^ change;
            m_tdata_next = M_TDATA_W'({FIELD_W'(long_press), FIELD_W'(change),
                                       FIELD_W'(level_next)});
        end else begin
            // First tick: load levels silently
            level_next   = pins;
            m_tdata_next = M_TDATA_W'(FIELD_W'(pins));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            level_reg    <= '0;
            prev_pin_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                started_reg  <= 1'b1;
                level_reg    <= level_next;
                prev_pin_reg <= pins;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                // Result taken and nothing new: drop valid
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> tb/button_debounce_long_press_test.sv
// Stream-level test of the five-channel debouncer with long-press detection.
module button_debounce_long_press_test;
    import bdlp_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] level;
        logic [FIELD_W-1:0] change;
        logic [FIELD_W-1:0] long_press;
    } tick_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;     // [4:0] pin_levels, [7:5] zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;     // [4:0] level_mask, [9:5] change_mask,
                                       // [14:10] long_press_mask, [15] zero
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    // Register copies
    logic [CFG_W-1:0]   db_ticks;
    logic [CFG_W-1:0]   lp_ticks;
    logic [FIELD_W-1:0] lp_enable;

    // Debouncer state as predicted
    logic               started;
    logic [FIELD_W-1:0] deb_level;
    logic [FIELD_W-1:0] prev_pins;
    logic [CFG_W-1:0]   db_cnt [FIELD_W];
    logic [FIELD_W-1:0] db_armed;
    logic [FIELD_W-1:0] recheck;
    logic [CFG_W-1:0]   hold_cnt [FIELD_W];
    logic [FIELD_W-1:0] hold_armed;

    tick_result_t       expected_ticks [$];
    logic [FIELD_W-1:0] pin_state;
    int                 mismatch_count = 0;
    int                 tick_index = 0;
    bit                 tx_no_gap = 1'b0;
    bit                 rx_no_stall = 1'b0;
    int                 rx_wait = 0;
    int                 rx_hold = 0;

    button_debounce_long_press i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] want,
                                   input logic [FIELD_W-1:0] got);
        $display("MISMATCH result %0d %s: expected %h, got %h", tick_index, what, want, got);
        mismatch_count++;
    endtask

    // Advance the predicted debouncer by one tick and queue its result
    task automatic debounce_predict(input logic [FIELD_W-1:0] pins);
        tick_result_t       r;
        logic [FIELD_W-1:0] lvl_in;
        logic               p, pp, lv, en, check;
        r.level      = '0;
        r.change     = '0;
        r.long_press = '0;
        if (!started) begin
            // first tick only loads the levels
            started   = 1'b1;
            deb_level = pins;
            prev_pins = pins;
            r.level   = pins;
        end else begin
            lvl_in  = deb_level;
            r.level = deb_level;
            for (int ch = 0; ch < FIELD_W; ch++) begin
                p     = pins[ch];
                pp    = prev_pins[ch];
                lv    = lvl_in[ch];
                en    = lp_enable[ch];
                check = 1'b0;
                // hold countdown runs off the state at the start of the tick
                if (hold_armed[ch]) begin
                    if (hold_cnt[ch] <= 1) begin
                        hold_armed[ch]   = 1'b0;
                        hold_cnt[ch]     = '0;
                        r.long_press[ch] = 1'b1;
                    end else begin
                        hold_cnt[ch]--;
                    end
                end
                if (pp == lv && p != lv) begin
                    db_cnt[ch]   = db_ticks;
                    db_armed[ch] = 1'b1;
                    recheck[ch]  = 1'b0;
                end else if (recheck[ch]) begin
                    recheck[ch] = 1'b0;
                    check       = 1'b1;
                end else if (db_armed[ch]) begin
                    if (db_cnt[ch] <= 1) begin
                        db_armed[ch] = 1'b0;
                        db_cnt[ch]   = '0;
                        check        = 1'b1;
                    end else begin
                        db_cnt[ch]--;
                    end
                end
                if (check) begin
                    if (!lv && p) begin
                        if (en) begin
                            hold_cnt[ch]   = lp_ticks;
                            hold_armed[ch] = 1'b1;
                        end
                    end else if (lv && !p) begin
                        if (en) hold_armed[ch] = 1'b0;
                    end else begin
                        // pin toggled back: flip anyway, look again next tick
                        recheck[ch] = 1'b1;
                    end
                    r.level[ch]  = ~r.level[ch];
                    r.change[ch] = 1'b1;
                end
            end
            deb_level = r.level;
            prev_pins = pins;
        end
        expected_ticks.push_back(r);
    endtask

    // Offer one tick of pin levels; returns at the falling edge after its transfer
    task automatic send_tick(input logic [FIELD_W-1:0] pins);
        int gap;
        gap = tx_no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = S_TDATA_W'(pins);
        do @(posedge aclk); while (!s_tready);
        debounce_predict(pins);
        @(negedge aclk);
    endtask

    task automatic wait_results_done();
        s_tvalid = 1'b0;
        while (expected_ticks.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_DEBOUNCE_TICKS:    db_ticks  = value;
            CFG_LONG_PRESS_TICKS:  lp_ticks  = value;
            CFG_LONG_PRESS_ENABLE: lp_enable = value[FIELD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                                  input logic [CFG_W-1:0] en_word);
        write_reg(CFG_DEBOUNCE_TICKS, db);
        write_reg(CFG_LONG_PRESS_TICKS, lp);
        write_reg(CFG_LONG_PRESS_ENABLE, en_word);
    endtask

    // Mostly button presses with contact bounce, some raw noise in between
    task automatic run_press_traffic(input int n_items);
        int                 sent;
        int                 span;
        int                 len;
        logic [FIELD_W-1:0] flip;
        logic [FIELD_W-1:0] target;
        sent = 0;
        span = int'(db_ticks) + int'(lp_ticks) + 4;
        if (span > 40) span = 40;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    pin_state = FIELD_W'($urandom);
                    send_tick(pin_state);
                    sent++;
                end
            end else begin
                flip = FIELD_W'($urandom);
                if (flip == '0) flip = FIELD_W'(1 << $urandom_range(0, FIELD_W - 1));
                target = pin_state ^ flip;
                repeat ($urandom_range(0, 3)) begin
                    send_tick(pin_state ^ (flip & FIELD_W'($urandom)));
                    sent++;
                end
                len = $urandom_range(1, span);
                repeat (len) begin
                    send_tick(target);
                    sent++;
                end
                pin_state = target;
            end
        end
    endtask

    // First tick loads silently, then a couple of edges under the reset settings
    task automatic test_first_tick_and_defaults();
        send_tick(5'h15);
        send_tick(5'h0A);
        send_tick(5'h1F);
        wait_results_done();
    endtask

    task automatic test_qualify_and_long_press();
        apply_settings(16'd0, 16'd4, 16'h001F);
        send_tick(5'h00);
        send_tick(5'h00);
        // glitch on channel 1: pin returns before the check
        send_tick(5'h02);
        send_tick(5'h00);
        send_tick(5'h00);
        // channel 2: fall lands on the tick the long press expires
        send_tick(5'h04);
        send_tick(5'h04);
        send_tick(5'h04);
        send_tick(5'h04);
        send_tick(5'h00);
        send_tick(5'h00);
        // channel 3: long press disabled after the rise keeps running
        send_tick(5'h08);
        send_tick(5'h08);
        wait_results_done();
        write_reg(CFG_LONG_PRESS_ENABLE, 16'hFFF7);
        repeat (4) send_tick(5'h00);
        wait_results_done();
    endtask

    task automatic test_count_extremes();
        apply_settings(16'hFFFF, 16'hFFFF, 16'h0000);
        send_tick(5'h1F);
        send_tick(5'h1F);
        send_tick(5'h00);
        send_tick(5'h00);
        wait_results_done();
        pin_state = 5'h00;
    endtask

    task automatic test_random_settings();
        apply_settings(16'd1, 16'd1, 16'h001F);
        run_press_traffic(200);
        wait_results_done();
        apply_settings(16'd0, 16'd0, 16'($urandom));
        run_press_traffic(200);
        wait_results_done();
        tx_no_gap   = 1'b1;
        rx_no_stall = 1'b1;
        apply_settings(16'($urandom_range(1, 6)), 16'($urandom_range(1, 25)), 16'($urandom));
        run_press_traffic(170);
        wait_results_done();
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
        apply_settings(16'hFFFF, 16'hFFFF, 16'h0000);
        run_press_traffic(20);
        wait_results_done();
        apply_settings(16'($urandom_range(2, 8)), 16'($urandom_range(5, 40)), 16'($urandom));
        run_press_traffic(200);
        wait_results_done();
    endtask

    // Receiver holds off while ticks keep coming, then the receiver drains
    task automatic test_output_backpressure();
        apply_settings(16'($urandom_range(1, 4)), 16'($urandom_range(1, 12)), 16'h001F);
        rx_hold   = 300;
        tx_no_gap = 1'b1;
        run_press_traffic(80);
        tx_no_gap = 1'b0;
        wait_results_done();
    endtask

    initial begin : ready_drive
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (rx_wait > 0) begin
                m_tready = 1'b0;
                rx_wait--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected result, level", '0, m_tdata[FIELD_W-1:0]);
            end else begin
                want = expected_ticks.pop_front();
                if (m_tdata[FIELD_W-1:0] !== want.level)
                    report_mismatch("level_mask", want.level, m_tdata[FIELD_W-1:0]);
                if (m_tdata[2*FIELD_W-1:FIELD_W] !== want.change)
                    report_mismatch("change_mask", want.change,
                                    m_tdata[2*FIELD_W-1:FIELD_W]);
                if (m_tdata[3*FIELD_W-1:2*FIELD_W] !== want.long_press)
                    report_mismatch("long_press_mask", want.long_press,
                                    m_tdata[3*FIELD_W-1:2*FIELD_W]);
            end
            tick_index++;
            rx_wait = rx_no_stall ? 0 : $urandom_range(0, 5);
        end
    end

    initial begin
        #2_000_000;
        $display("button_debounce_long_press_test failed");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_DEBOUNCE_TICKS;
        cfg_wdata = '0;
        db_ticks  = DEBOUNCE_TICKS_RST;
        lp_ticks  = LONG_PRESS_TICKS_RST;
        lp_enable = LONG_PRESS_ENABLE_RST;
        started   = 1'b0;
        deb_level = '0;
        prev_pins = '0;
        db_armed  = '0;
        recheck   = '0;
        hold_armed = '0;
        pin_state = '0;
        for (int ch = 0; ch < FIELD_W; ch++) begin
            db_cnt[ch]   = '0;
            hold_cnt[ch] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_first_tick_and_defaults();
        test_qualify_and_long_press();
        test_count_extremes();
        test_random_settings();
        test_output_backpressure();

        wait_results_done();
        repeat (5) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("button_debounce_long_press_test passed");
        end else begin
            $display("button_debounce_long_press_test failed");
        end
        $finish;
    end

endmodule

>>> button_debounce_long_press.f
sv/bdlp_pkg.sv
sv/bdlp_channel.sv
sv/button_debounce_long_press.sv
tb/button_debounce_long_press_test.sv
